>>> rtl/chm_pkg.sv
// shared constants and types of the chained hash map
package chm_pkg;

	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int OP_W       = 2;
	localparam int STAT_W     = 2;
	localparam int COUNT_W    = 7;
	localparam int CFG_W      = 6;
	localparam int HASH_SHIFT = 4;
	localparam int HKEY_W     = KEY_W - HASH_SHIFT;
	localparam int MOD_STEP   = 4;
	localparam int MOD_CYC    = HKEY_W / MOD_STEP;
	localparam int MOD_CNT_W  = $clog2(MOD_CYC + 1);
	localparam int IN_W       = 72;
	localparam int OUT_W      = 48;

	localparam logic [CFG_W-1:0] DEFAULT_BUCKETS = 6'd17;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_SET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	// handshake between the sequencer and the modulo unit
	typedef struct packed {
		logic start;
	} mod_req_t;

	typedef struct packed {
		logic done;
	} mod_rsp_t;

endpackage

>>> rtl/chained_hash_map.sv
// Key-to-value map of 32-bit words with separate chaining: each transaction is a lookup, a set
// or a remove and gives one result with found, the value read, a status and the entry count.
// An operation steps through acceptance, the bucket remainder (four quotient bits a cycle), the
// bucket head read and one step per chain entry visited before a hit or the chain end (key, value
// and link read together from their memories), then one or two write-back steps and the loading
// of the result. After reset and after every bucket_count write all BUCKETS bucket heads are
// cleared one a cycle, during which no operation is accepted. A new operation is accepted while
// an earlier result still waits on the output.
module chained_hash_map import chm_pkg::*; #(
	parameter int BUCKETS = 32,
	parameter int ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // operation[1:0], key[33:2], value[65:34], zero pad
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // found[0], read_value[32:1], status[34:33],
	                                     // entry_count[41:35], zero pad
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int LW = $clog2(ENTRIES + 1);
	localparam int EW = $clog2(ENTRIES);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW = $clog2(BUCKETS + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_NODE, S_ACT, S_ALLOC, S_UNLINK, S_DONE
	} state_t;

	state_t            state_q;
	logic [BW-1:0]     clr_q;
	logic [CFG_W-1:0]  bcount_q;
	logic [NW-1:0]     nb;
	logic [LW-1:0]     free_head_q;
	logic [LW-1:0]     fill_q;
	logic [LW-1:0]     count_q;
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [BW-1:0]     bucket_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     cur_q;
	logic [LW-1:0]     prev_q;
	logic [LW-1:0]     link_cur_q;
	logic [VAL_W-1:0]  hit_val_q;
	logic              found_q;
	logic              o_found_q;
	logic [VAL_W-1:0]  o_val_q;
	status_t           o_stat_q;
	logic [LW-1:0]     o_count_q;
	logic              m_valid_q;
	status_t           res_stat_q;

	mod_req_t          mreq;
	mod_rsp_t          mrsp;
	logic [NW-1:0]     mrem;

	logic              hd_we;
	logic [BW-1:0]     hd_waddr, hd_raddr;
	logic [LW-1:0]     hd_wdata, hd_rdata;
	logic              lk_we, ky_we, vl_we;
	logic [EW-1:0]     lk_waddr, ky_waddr, vl_waddr, nd_raddr;
	logic [LW-1:0]     lk_wdata, lk_rdata, nd_rsel;
	logic [VAL_W-1:0]  vl_wdata, vl_rdata;
	logic [KEY_W-1:0]  ky_rdata;

	logic in_acc, cfg_acc, out_load, is_set, is_rem;

	assign in_acc   = s_tvalid && s_tready;
	assign cfg_acc  = cfg_valid && cfg_ready;
	// a pending register write takes precedence over a new operation
	assign s_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_tready);
	assign is_set   = (op_q == OP_SET);
	assign is_rem   = (op_q == OP_REMOVE);

	// bucket count clamped to the supported range
	always_comb begin
		if (bcount_q == '0) begin
			nb = NW'(1);
		end else if (32'(bcount_q) > 32'(BUCKETS)) begin
			nb = NW'(BUCKETS);
		end else begin
			nb = NW'(bcount_q);
		end
	end

	assign mreq.start = in_acc;

	chm_mod #(.NW(NW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mreq),
		.dividend (s_tdata[OP_W + HASH_SHIFT +: HKEY_W]),
		.divisor  (nb),
		.rsp      (mrsp),
		.rem      (mrem)
	);

	// node address: head of the chain, next link, or free head for allocation
	always_comb begin
		unique case (state_q)
			S_HEAD:  nd_rsel = hd_rdata;
			S_NODE:  nd_rsel = lk_rdata;
			default: nd_rsel = free_head_q;
		endcase
		nd_raddr = nd_rsel[EW-1:0];
		hd_raddr = mrem[BW-1:0];
	end

	// memory write steering
	always_comb begin
		hd_we = 1'b0; hd_waddr = bucket_q; hd_wdata = link_cur_q;
		lk_we = 1'b0; lk_waddr = prev_q[EW-1:0]; lk_wdata = link_cur_q;
		ky_we = 1'b0; ky_waddr = free_head_q[EW-1:0];
		vl_we = 1'b0; vl_waddr = free_head_q[EW-1:0]; vl_wdata = val_q;
		unique case (state_q)
			S_CLEAR: begin
				hd_we    = 1'b1;
				hd_waddr = clr_q;
				hd_wdata = NULL_LINK;
			end
			S_ACT: begin
				if (is_set && found_q) begin
					vl_we    = 1'b1;
					vl_waddr = cur_q[EW-1:0];
				end
				if (is_rem && found_q) begin
					if (prev_q == NULL_LINK) begin
						hd_we = 1'b1;
					end else begin
						lk_we = 1'b1;
					end
				end
			end
			S_ALLOC: begin
				hd_we    = 1'b1;
				hd_wdata = free_head_q;
				lk_we    = 1'b1;
				lk_waddr = free_head_q[EW-1:0];
				lk_wdata = head_q;
				ky_we    = 1'b1;
				vl_we    = 1'b1;
			end
			S_UNLINK: begin
				lk_we    = 1'b1;
				lk_waddr = cur_q[EW-1:0];
				lk_wdata = free_head_q;
			end
			S_IDLE, S_HASH, S_HEAD, S_NODE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.raddr(hd_raddr), .rdata(hd_rdata)
	);
	chm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_links (
		.clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
		.raddr(nd_raddr), .rdata(lk_rdata)
	);
	chm_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_keys (
		.clk(clk), .we(ky_we), .waddr(ky_waddr), .wdata(key_q),
		.raddr(nd_raddr), .rdata(ky_rdata)
	);
	chm_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_vals (
		.clk(clk), .we(vl_we), .waddr(vl_waddr), .wdata(vl_wdata),
		.raddr(nd_raddr), .rdata(vl_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			bcount_q    <= DEFAULT_BUCKETS;
			free_head_q <= '0;
			fill_q      <= '0;
			count_q     <= '0;
			m_valid_q   <= 1'b0;
			found_q     <= 1'b0;
			res_stat_q  <= ST_OK;
			prev_q      <= NULL_LINK;
			cur_q       <= NULL_LINK;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_acc) begin
				bcount_q    <= cfg_data;
				state_q     <= S_CLEAR;
				clr_q       <= '0;
				free_head_q <= '0;
				fill_q      <= '0;
				count_q     <= '0;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == BW'(BUCKETS - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_acc) begin
							state_q <= S_HASH;
						end
					end
					S_HASH: begin
						if (mrsp.done) begin
							state_q <= S_HEAD;
						end
					end
					S_HEAD: begin
						prev_q <= NULL_LINK;
						cur_q  <= hd_rdata;
						if (hd_rdata == NULL_LINK) begin
							found_q <= 1'b0;
							state_q <= S_ACT;
						end else begin
							state_q <= S_NODE;
						end
					end
					S_NODE: begin
						if (ky_rdata == key_q) begin
							found_q <= 1'b1;
							state_q <= S_ACT;
						end else begin
							prev_q <= cur_q;
							cur_q  <= lk_rdata;
							if (lk_rdata == NULL_LINK) begin
								found_q <= 1'b0;
								state_q <= S_ACT;
							end
						end
					end
					S_ACT: begin
						state_q <= S_DONE;
						if (is_set) begin
							if (found_q) begin
								res_stat_q <= ST_OK;
							end else if (count_q == LW'(ENTRIES)) begin
								res_stat_q <= ST_FULL;
							end else begin
								res_stat_q <= ST_OK;
								state_q    <= S_ALLOC;
							end
						end else if (is_rem) begin
							res_stat_q <= found_q ? ST_OK : ST_MISS;
							if (found_q) begin
								state_q <= S_UNLINK;
							end
						end else begin
							res_stat_q <= found_q ? ST_OK : ST_MISS;
						end
					end
					S_ALLOC: begin
						// entries at or past the fill mark are free in index order
						if (free_head_q == fill_q) begin
							free_head_q <= fill_q + 1'b1;
							fill_q      <= fill_q + 1'b1;
						end else begin
							free_head_q <= lk_rdata;
						end
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end
					S_UNLINK: begin
						free_head_q <= cur_q;
						count_q     <= count_q - 1'b1;
						state_q     <= S_DONE;
					end
					S_DONE: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= op_t'(s_tdata[OP_W-1:0]);
			key_q <= s_tdata[OP_W +: KEY_W];
			val_q <= s_tdata[OP_W + KEY_W +: VAL_W];
		end
		if (state_q == S_HASH && mrsp.done) begin
			bucket_q <= mrem[BW-1:0];
		end
		if (state_q == S_HEAD) begin
			head_q <= hd_rdata;
		end
		if (state_q == S_NODE && ky_rdata == key_q) begin
			link_cur_q <= lk_rdata;
			hit_val_q  <= vl_rdata;
		end
		if (out_load) begin
			o_found_q <= found_q;
			o_val_q   <= (!is_set && !is_rem && found_q) ? hit_val_q : '0;
			o_stat_q  <= res_stat_q;
			o_count_q <= count_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_W - 1 - VAL_W - STAT_W - COUNT_W){1'b0}},
		COUNT_W'(o_count_q), o_stat_q, o_val_q, o_found_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LW'(ENTRIES))
		else $error("entry count above pool size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == LW'(ENTRIES)) == (free_head_q == NULL_LINK))
		else $error("free list disagrees with entry count");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> (state_q == S_CLEAR) && (count_q == '0) && (fill_q == '0))
		else $error("register write did not clear the store");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |-> (count_q != LW'(ENTRIES)) && is_set && !found_q)
		else $error("allocation without a free entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UNLINK) |-> is_rem && found_q && (count_q != '0))
		else $error("unlink of an absent entry");

endmodule

>>> rtl/chm_ram.sv
// generic single write port, single read port ram with registered read
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/chm_mod.sv
// iterative remainder of the shifted key by the bucket count, four bits a cycle
module chm_mod import chm_pkg::*; #(
	parameter int NW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mod_req_t          req,
	input  logic [HKEY_W-1:0] dividend,
	input  logic [NW-1:0]     divisor,
	output mod_rsp_t          rsp,
	output logic [NW-1:0]     rem
);

	logic [HKEY_W-1:0]    dd_q;
	logic [NW-1:0]        r_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [NW-1:0]        r_next;
	logic [NW:0]          t;

	always_comb begin
		r_next = r_q;
		for (int i = 0; i < MOD_STEP; i++) begin
			t = {r_next, dd_q[HKEY_W-1-i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r_next = t[NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_CYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dd_q <= dividend;
			r_q  <= '0;
		end else if (busy_q) begin
			dd_q <= dd_q << MOD_STEP;
			r_q  <= r_next;
		end
	end

	assign rsp.done = done_q;
	assign rem      = r_q;

endmodule
